FILE: design/sem_pkg.sv
// ----------------------------------------------------------------------------
// sem_pkg
// shared types and constants of the sobel edge magnitude block
// ----------------------------------------------------------------------------
package sem_pkg;

    localparam int FW_BITS       = 11;
    localparam int FH_BITS       = 12;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 12;
    localparam int MIN_DIM       = 3;

    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_HEIGHT = 2'd1;

    localparam logic [FW_BITS-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [FH_BITS-1:0] HEIGHT_RESET = 12'd480;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD,
        ST_GRAD,
        ST_SQUARE,
        ST_SUM,
        ST_ROOT,
        ST_OUT
    } sem_state_t;

    typedef struct packed {
        logic clear;
        logic accept;
        logic load;
        logic grad;
        logic square;
        logic sum;
        logic root;
        logic out_load;
    } sem_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic interior;
        logic root_last;
        logic out_free;
    } sem_stat_t;

endpackage

FILE: design/sem_pix_if.sv
// ----------------------------------------------------------------------------
// sem_pix_if
// pixel stream channel, valid/ready with one pixel per item
// ----------------------------------------------------------------------------
interface sem_pix_if #(
    parameter int PIXEL_BITS = 8
);
    logic                  valid;
    logic                  ready;
    logic [PIXEL_BITS-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

FILE: design/sem_mag_if.sv
// ----------------------------------------------------------------------------
// sem_mag_if
// result channel, valid/ready with magnitude and end-of-frame flag
// ----------------------------------------------------------------------------
interface sem_mag_if #(
    parameter int PIXEL_BITS = 8
);
    logic                  valid;
    logic                  ready;
    logic [PIXEL_BITS-1:0] magnitude;
    logic                  frame_done;

    modport source (output valid, output magnitude, output frame_done, input ready);
    modport sink   (input valid, input magnitude, input frame_done, output ready);
endinterface

FILE: design/sem_cfg_if.sv
// ----------------------------------------------------------------------------
// sem_cfg_if
// register write channel, valid/ready with index and data
// ----------------------------------------------------------------------------
interface sem_cfg_if
    import sem_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: design/sobel_edge_magnitude.sv
// ----------------------------------------------------------------------------
// sobel_edge_magnitude
// 3x3 sobel gradient magnitude over a raster pixel stream
// channels: cfg (register writes, always ready), pixels in, results out
// each pixel is one item; interior pixels give one result item each,
// border rows and columns give none; frame_done marks the last result
// per item, a border pixel passes through intake and load only; an
// interior pixel passes through load, gradient, square, sum, PIXEL_BITS+3
// root steps of the bit-serial square root unit and output load
// after reset the whole line store is cleared, no pixel taken
// a finished result waits in the output register; the next pixel is taken
// meanwhile, and a new result stalls only while that register is full
// ----------------------------------------------------------------------------
module sobel_edge_magnitude
    import sem_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 8
) (
    input  logic    clk,
    input  logic    rst_n,
    sem_cfg_if.sink cfg,
    sem_pix_if.sink pixels,
    sem_mag_if.source results
);

    sem_cmd_t  cmd;
    sem_stat_t stat;
    logic      in_ready;

    // register writes are taken in any cycle
    assign cfg.ready    = 1'b1;
    assign pixels.ready = in_ready;

    sem_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pixels.valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sem_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg.valid),
        .cfg_index      (cfg.index),
        .cfg_data       (cfg.data),
        .in_pixel       (pixels.pixel),
        .cmd            (cmd),
        .stat           (stat),
        .out_ready      (results.ready),
        .out_valid      (results.valid),
        .out_magnitude  (results.magnitude),
        .out_frame_done (results.frame_done)
    );

`ifndef SYNTHESIS
    // no pixel is taken during the clearing pass
    a_no_take_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |-> !pixels.ready)
        else $error("pixel ready during line store clear");

    // a result only enters a free output register
    a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> stat.out_free)
        else $error("result loaded into full output register");

    // an accepted pixel is loaded into the window in the next cycle
    a_accept_load: assert property (@(posedge clk) disable iff (!rst_n)
        (pixels.valid && pixels.ready) |=> cmd.load)
        else $error("accepted pixel not loaded");
`endif

endmodule

FILE: design/sem_ctrl.sv
// ----------------------------------------------------------------------------
// sem_ctrl
// sequencer: clearing pass, item intake, gradient, square, root, output
// ----------------------------------------------------------------------------
module sem_ctrl
    import sem_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  sem_stat_t stat,
    output sem_cmd_t  cmd
);

    sem_state_t state_reg;
    sem_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:  if (stat.clear_last) state_next = ST_IDLE;
            ST_IDLE:   if (in_valid) state_next = ST_LOAD;
            ST_LOAD:   state_next = stat.interior ? ST_GRAD : ST_IDLE;
            ST_GRAD:   state_next = ST_SQUARE;
            ST_SQUARE: state_next = ST_SUM;
            ST_SUM:    state_next = ST_ROOT;
            ST_ROOT:   if (stat.root_last) state_next = ST_OUT;
            ST_OUT:    if (stat.out_free) state_next = ST_IDLE;
            default:   state_next = ST_CLEAR;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_CLEAR:  cmd.clear = 1'b1;
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            ST_LOAD:   cmd.load = 1'b1;
            ST_GRAD:   cmd.grad = 1'b1;
            ST_SQUARE: cmd.square = 1'b1;
            ST_SUM:    cmd.sum = 1'b1;
            ST_ROOT:   cmd.root = 1'b1;
            ST_OUT:    cmd.out_load = stat.out_free;
            default:   cmd = '0;
        endcase
    end

endmodule

FILE: design/sem_datapath.sv
// ----------------------------------------------------------------------------
// sem_datapath
// line store, window, counters, gradient and iterative square root
// ----------------------------------------------------------------------------
module sem_datapath
    import sem_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 8
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_write,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    input  logic [PIXEL_BITS-1:0]    in_pixel,
    input  sem_cmd_t                 cmd,
    output sem_stat_t                stat,
    input  logic                     out_ready,
    output logic                     out_valid,
    output logic [PIXEL_BITS-1:0]    out_magnitude,
    output logic                     out_frame_done
);

    localparam int PW  = PIXEL_BITS;
    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int EW  = (CW + 1 > FW_BITS) ? CW + 1 : FW_BITS;
    localparam int GW  = PW + 3;
    localparam int SQW = 2 * GW;
    localparam int QW  = 2 * GW - 2;

    localparam logic [EW-1:0]      EW_MIN   = EW'(MIN_DIM);
    localparam logic [EW-1:0]      EW_MAX   = EW'(MAX_WIDTH);
    localparam logic [FH_BITS-1:0] FH_MIN   = FH_BITS'(MIN_DIM);
    localparam logic [CW-1:0]      CLR_LAST = CW'(MAX_WIDTH - 1);
    localparam logic [SQW-1:0]     PIX_MAX  = SQW'((1 << PW) - 1);

    // configuration
    logic [FW_BITS-1:0] fw_reg;
    logic [FH_BITS-1:0] fh_reg;
    logic [EW-1:0]      fw_ext;
    logic [EW-1:0]      w_eff;
    logic [FH_BITS-1:0] h_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg <= WIDTH_RESET;
            fh_reg <= HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            if (cfg_index == CFG_FRAME_WIDTH)
                fw_reg <= cfg_data[FW_BITS-1:0];
            else if (cfg_index == CFG_FRAME_HEIGHT)
                fh_reg <= cfg_data[FH_BITS-1:0];
        end
    end

    assign fw_ext = EW'(fw_reg);
    assign w_eff  = (fw_ext < EW_MIN) ? EW_MIN : ((fw_ext > EW_MAX) ? EW_MAX : fw_ext);
    assign h_eff  = (fh_reg < FH_MIN) ? FH_MIN : fh_reg;

    // line store: entry holds {row r-2, row r-1}
    logic [2*PW-1:0] line_mem [MAX_WIDTH];
    logic [2*PW-1:0] rd_data_reg;
    logic [CW-1:0]   clr_addr_reg;
    logic [CW-1:0]   col_reg;
    logic [CW-1:0]   col_next;
    logic [FH_BITS-1:0] row_reg;
    logic [FH_BITS-1:0] row_next;
    logic [EW-1:0]   col_ext;
    logic [PW-1:0]   pix_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.clear)
            line_mem[clr_addr_reg] <= '0;
        else if (cmd.load)
            line_mem[col_reg] <= {rd_data_reg[PW-1:0], pix_reg};
        if (cmd.accept)
            rd_data_reg <= line_mem[col_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_addr_reg <= '0;
        else if (cmd.clear)
            clr_addr_reg <= clr_addr_reg + CW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
            pix_reg <= in_pixel;
    end

    // position counters
    assign col_ext = EW'(col_reg);

    always_comb
    begin
        col_next = col_reg + CW'(1);
        row_next = row_reg;
        if (col_ext >= w_eff - EW'(1))
        begin
            col_next = '0;
            row_next = (row_reg >= h_eff - FH_BITS'(1)) ? '0 : row_reg + FH_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (cmd.load)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // 3x3 window, column 2 newest
    logic [PW-1:0] win_reg [3][3];
    logic          done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    win_reg[i][j] <= '0;
        end
        else if (cmd.load)
        begin
            for (int i = 0; i < 3; i++)
            begin
                win_reg[i][0] <= win_reg[i][1];
                win_reg[i][1] <= win_reg[i][2];
            end
            win_reg[0][2] <= rd_data_reg[2*PW-1:PW];
            win_reg[1][2] <= rd_data_reg[PW-1:0];
            win_reg[2][2] <= pix_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            done_reg <= (row_reg == h_eff - FH_BITS'(1)) && (col_ext == w_eff - EW'(1));
    end

    assign stat.interior = (row_reg >= FH_BITS'(2)) && (col_ext >= EW'(2))
                        && (row_reg < h_eff) && (col_ext < w_eff);
    assign stat.clear_last = (clr_addr_reg == CLR_LAST);

    // gradients
    logic [PW+1:0]        gx_pos;
    logic [PW+1:0]        gx_neg;
    logic [PW+1:0]        gy_pos;
    logic [PW+1:0]        gy_neg;
    logic signed [GW-1:0] gx_reg;
    logic signed [GW-1:0] gy_reg;

    assign gx_pos = (PW+2)'(win_reg[0][2]) + ((PW+2)'(win_reg[1][2]) << 1)
                  + (PW+2)'(win_reg[2][2]);
    assign gx_neg = (PW+2)'(win_reg[0][0]) + ((PW+2)'(win_reg[1][0]) << 1)
                  + (PW+2)'(win_reg[2][0]);
    assign gy_pos = (PW+2)'(win_reg[0][0]) + ((PW+2)'(win_reg[0][1]) << 1)
                  + (PW+2)'(win_reg[0][2]);
    assign gy_neg = (PW+2)'(win_reg[2][0]) + ((PW+2)'(win_reg[2][1]) << 1)
                  + (PW+2)'(win_reg[2][2]);

    always_ff @(posedge clk)
    begin
        if (cmd.grad)
        begin
            gx_reg <= $signed({1'b0, gx_pos}) - $signed({1'b0, gx_neg});
            gy_reg <= $signed({1'b0, gy_pos}) - $signed({1'b0, gy_neg});
        end
    end

    // squares
    logic signed [2*GW-1:0] gx_sq;
    logic signed [2*GW-1:0] gy_sq;
    logic [QW-1:0]          sqx_reg;
    logic [QW-1:0]          sqy_reg;

    assign gx_sq = gx_reg * gx_reg;
    assign gy_sq = gy_reg * gy_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.square)
        begin
            sqx_reg <= gx_sq[QW-1:0];
            sqy_reg <= gy_sq[QW-1:0];
        end
    end

    // bitwise square root, one result bit per cycle
    logic [SQW-1:0] rem_reg;
    logic [SQW-1:0] root_reg;
    logic [SQW-1:0] bit_reg;
    logic [SQW-1:0] trial;

    assign trial = root_reg + bit_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.sum)
        begin
            rem_reg  <= SQW'(sqx_reg) + SQW'(sqy_reg);
            root_reg <= '0;
            bit_reg  <= SQW'(1) << (SQW - 2);
        end
        else if (cmd.root)
        begin
            if (rem_reg >= trial)
            begin
                rem_reg  <= rem_reg - trial;
                root_reg <= (root_reg >> 1) + bit_reg;
            end
            else
            begin
                root_reg <= root_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign stat.root_last = bit_reg[0];

    // output register
    logic          out_valid_reg;
    logic          out_valid_next;
    logic [PW-1:0] mag_reg;
    logic          fdone_reg;

    assign stat.out_free  = !out_valid_reg || out_ready;
    assign out_valid_next = cmd.out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            mag_reg   <= (root_reg > PIX_MAX) ? PIX_MAX[PW-1:0] : root_reg[PW-1:0];
            fdone_reg <= done_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_magnitude  = mag_reg;
    assign out_frame_done = fdone_reg;

endmodule
